@@ rtl/assert_macros.svh @@
// Assertion macros shared by the RTL of the pitch quantizer.
// Clock i_clk and active-low reset i_rst_n are taken from the using module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define WSPQ_ASSERT(label, prop) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("wspq assertion failed");
`define WSPQ_NEVER(label, expr) `WSPQ_ASSERT(label, !(expr))
`else
`define WSPQ_ASSERT(label, prop)
`define WSPQ_NEVER(label, expr)
`endif
`endif

@@ rtl/wspq_pkg.sv @@
// Constants of the weighted scale pitch quantizer.
// No dependencies; imported by the top level.
`default_nettype none
package wspq_pkg;
    localparam int REG_W        = 54;     // width of one weight register
    localparam int VIN_W        = 16;     // input voltage width
    localparam int VOUT_W       = 14;     // output voltage width
    localparam int SEMI_UNITS   = 256;    // units per semitone
    localparam int OCTAVE_UNITS = 3072;   // units per octave
    localparam int WEIGHT_MAX   = 256;    // weight saturation
    localparam int OUT_MAX      = 15360;  // 5 V
    localparam int CAND_W       = 18;     // signed candidate and difference width
    localparam int DIST_W       = 17;     // unsigned distance width

    localparam logic [1:0] REG_WEIGHTS_LOW  = 2'd0;
    localparam logic [1:0] REG_WEIGHTS_HIGH = 2'd1;
endpackage
`default_nettype wire

@@ rtl/weighted_scale_pitch_quantizer_top.sv @@
// Weighted scale pitch quantizer: snaps a 1V/oct voltage to a weighted scale.
// Depends on wspq_pkg and assert_macros.svh.
//
// Usage:
//   Input stream s_axis_*: one signed voltage per transfer, 1/3072 V units.
//   Output stream m_axis_*: one quantized voltage per input, 0..15360.
//   Config channel i_cfg_*: index 0 writes weights_low, index 1 weights_high,
//   any other index is ignored; o_cfg_ready is always high. Write only idle.
// Timing:
//   A new voltage scans 3 octaves x SEMITONES semitones, one candidate per
//   cycle through a single distance/cross-multiply/compare unit, then is
//   clamped in ST_FIN and handed to the output register from ST_DONE.
//   The next input is accepted only once the sequencer is back in ST_IDLE.
//   A voltage equal to the previous one skips the scan and goes to ST_DONE.
// Reset:
//   Synchronous, active low. Weights clear to zero, the remembered input
//   becomes -32768 and the remembered output zero.
// Backpressure:
//   The output register holds its transfer while m_axis_tready is low; the
//   next voltage is still accepted and scanned, and its result waits in the
//   sequencer until the output register frees up.
`default_nettype none
`include "assert_macros.svh"
module weighted_scale_pitch_quantizer_top
    import wspq_pkg::*;
#(
    parameter int SEMITONES   = 12,
    parameter int WEIGHT_BITS = 9
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              s_axis_tvalid,
    output logic                   s_axis_tready,
    input  wire logic [15:0]       s_axis_tdata,   // [15:0] voltage_in
    output logic                   m_axis_tvalid,
    input  wire logic              m_axis_tready,
    output logic [15:0]            m_axis_tdata,   // [13:0] voltage_out, [15:14] zero
    input  wire logic              i_cfg_valid,
    output logic                   o_cfg_ready,
    input  wire logic [1:0]        i_cfg_index,
    input  wire logic [REG_W-1:0]  i_cfg_data
);
    localparam int S_W = (SEMITONES > 1) ? $clog2(SEMITONES) : 1;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SCAN = 2'd1;
    localparam logic [1:0] ST_FIN  = 2'd2;
    localparam logic [1:0] ST_DONE = 2'd3;

    // Step from the top octave of one semitone to the low octave of the next.
    localparam int NEXT_SEMI_STEP = SEMI_UNITS - 2 * OCTAVE_UNITS;

    logic [1:0]              r_state;
    logic [REG_W-1:0]        r_weights_low;
    logic [REG_W-1:0]        r_weights_high;
    logic signed [VIN_W-1:0] r_last_in;
    logic [VOUT_W-1:0]       r_last_out;
    logic signed [VIN_W-1:0] r_vin;
    logic [S_W-1:0]          r_semi;
    logic [1:0]              r_oct;
    logic signed [CAND_W-1:0] r_cand;
    logic                    r_any;
    logic                    r_hit;
    logic                    r_near;
    logic [8:0]              r_hit_w;
    logic [DIST_W-1:0]       r_hit_d;
    logic signed [CAND_W-1:0] r_hit_v;
    logic [DIST_W-1:0]       r_near_d;
    logic signed [CAND_W-1:0] r_near_v;
    logic [VOUT_W-1:0]       r_res;
    logic                    r_out_valid;
    logic [VOUT_W-1:0]       r_out_data;

    // Clamped weight of every implemented semitone.
    logic [8:0] weights [SEMITONES];

    for (genvar k = 0; k < SEMITONES; k++) begin : g_weight
        localparam int SH = (k % 6) * WEIGHT_BITS;
        logic [63:0]            reg_ext;
        logic [WEIGHT_BITS-1:0] field;
        logic [10:0]            field_ext;
        assign reg_ext   = {10'd0, ((k < 6) ? r_weights_low : r_weights_high)};
        assign field     = WEIGHT_BITS'(reg_ext >> SH);
        assign field_ext = 11'(field);
        assign weights[k] = (field_ext > 11'(WEIGHT_MAX)) ? 9'(WEIGHT_MAX) : 9'(field_ext);
    end

    // Octave of the input, truncated toward zero: |v|/3072 = (|v|>>10)/3,
    // the divide by 3 done as *43>>7, exact for quotients up to 32.
    logic signed [VIN_W-1:0]  vin_in;
    logic [VIN_W-1:0]         vin_abs;
    logic [5:0]               kilo;
    logic [11:0]              kilo_x43;
    logic [3:0]               oct_mag;
    logic signed [4:0]        oct_in;
    logic signed [CAND_W-1:0] base_cand;

    assign vin_in   = s_axis_tdata;
    assign vin_abs  = vin_in[VIN_W-1] ? VIN_W'(-$signed({vin_in[VIN_W-1], vin_in}))
                                      : $unsigned(vin_in);
    assign kilo     = vin_abs[VIN_W-1:10];
    assign kilo_x43 = 12'(kilo) * 12'd43;
    assign oct_mag  = kilo_x43[10:7];
    assign oct_in   = vin_in[VIN_W-1] ? -$signed({1'b0, oct_mag}) : $signed({1'b0, oct_mag});
    assign base_cand = CAND_W'((oct_in - 5'sd1) * $signed(CAND_W'(OCTAVE_UNITS)));

    // Shared scan unit: distance, capture test, cross-multiplied score compare.
    logic [8:0]               w_cur;
    logic signed [CAND_W-1:0] diff;
    logic [DIST_W-1:0]        cand_dist;
    logic [26:0]              score_kept;
    logic [26:0]              score_cand;
    logic                     captured;
    logic                     better;
    logic                     closer;
    logic                     scan_last;

    assign w_cur      = weights[r_semi];
    assign diff       = CAND_W'($signed(r_vin)) - r_cand;
    assign cand_dist  = diff[CAND_W-1] ? DIST_W'(-diff) : DIST_W'(diff);
    assign score_kept = 27'(w_cur) * 27'({1'b0, r_hit_d} + 18'd1);
    assign score_cand = 27'(r_hit_w) * 27'({1'b0, cand_dist} + 18'd1);
    assign captured   = ({8'd0, w_cur} >= cand_dist) && (w_cur != 9'd0);
    assign better     = !r_hit || (score_kept > score_cand);
    assign closer     = !r_near || (cand_dist < r_near_d);
    assign scan_last  = (r_semi == S_W'(SEMITONES - 1)) && (r_oct == 2'd2);

    // Final selection and 0..5 V clamp.
    logic signed [CAND_W-1:0] pick;
    logic [VOUT_W-1:0]        clamped;

    always_comb begin
        priority if (!r_any) begin
            pick = CAND_W'(r_vin);
        end else if (r_hit) begin
            pick = r_hit_v;
        end else begin
            pick = r_near_v;
        end
        priority if (pick < 0) begin
            clamped = '0;
        end else if (pick > CAND_W'(OUT_MAX)) begin
            clamped = VOUT_W'(OUT_MAX);
        end else begin
            clamped = VOUT_W'(pick);
        end
    end

    logic in_xfer;
    logic out_free;
    assign in_xfer  = s_axis_tvalid && s_axis_tready;
    assign out_free = !r_out_valid || m_axis_tready;

    assign s_axis_tready = (r_state == ST_IDLE);
    assign o_cfg_ready   = 1'b1;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {2'b00, r_out_data};

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_weights_low  <= '0;
            r_weights_high <= '0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_WEIGHTS_LOW:  r_weights_low  <= i_cfg_data;
                REG_WEIGHTS_HIGH: r_weights_high <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Sequencer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_last_in  <= VIN_W'(-32768);
            r_last_out <= '0;
            r_any      <= 1'b0;
            r_hit      <= 1'b0;
            r_near     <= 1'b0;
        end else begin
            unique case (r_state)
                ST_IDLE: begin
                    if (in_xfer) begin
                        if (vin_in == r_last_in) begin
                            // Same voltage again: replay the stored result.
                            r_res   <= r_last_out;
                            r_state <= ST_DONE;
                        end else begin
                            r_last_in <= vin_in;
                            r_vin     <= vin_in;
                            r_cand    <= base_cand;
                            r_semi    <= '0;
                            r_oct     <= 2'd0;
                            r_any     <= 1'b0;
                            r_hit     <= 1'b0;
                            r_near    <= 1'b0;
                            r_state   <= ST_SCAN;
                        end
                    end
                end
                ST_SCAN: begin
                    if (w_cur != 9'd0) begin
                        r_any <= 1'b1;
                        if (captured && better) begin
                            r_hit   <= 1'b1;
                            r_hit_w <= w_cur;
                            r_hit_d <= cand_dist;
                            r_hit_v <= r_cand;
                        end
                        if (closer) begin
                            r_near   <= 1'b1;
                            r_near_d <= cand_dist;
                            r_near_v <= r_cand;
                        end
                    end
                    // Advance octave first, then semitone.
                    if (r_oct == 2'd2) begin
                        r_oct  <= 2'd0;
                        r_semi <= r_semi + S_W'(1);
                        r_cand <= r_cand + CAND_W'(NEXT_SEMI_STEP);
                    end else begin
                        r_oct  <= r_oct + 2'd1;
                        r_cand <= r_cand + CAND_W'(OCTAVE_UNITS);
                    end
                    if (scan_last) begin
                        r_state <= ST_FIN;
                    end
                end
                ST_FIN: begin
                    r_res      <= clamped;
                    r_last_out <= clamped;
                    r_state    <= ST_DONE;
                end
                ST_DONE: begin
                    if (out_free) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == ST_DONE && out_free) begin
            r_out_valid <= 1'b1;
            r_out_data  <= r_res;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    `WSPQ_ASSERT(a_done_loads_out, (r_state == ST_DONE && out_free) |=> r_out_valid)
    `WSPQ_ASSERT(a_accept_leaves_idle, in_xfer |=> (r_state != ST_IDLE))
    `WSPQ_NEVER(a_out_in_range, r_out_valid && (r_out_data > VOUT_W'(OUT_MAX)))
    `WSPQ_NEVER(a_hit_within_radius, r_hit && (r_hit_d > DIST_W'(r_hit_w)))

endmodule
`default_nettype wire
